// ===== hw/rtl/sll_pkg.sv =====
// Package: shared types and constants for the sorted list engine.
`timescale 1ns / 1ps
package sll_pkg;
  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_FIND   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_POS  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] data_value;
    logic [3:0]         position;
  } sll_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] result_value;
    logic [3:0]         found_position;
    logic [4:0]         entry_count;
  } sll_out_t;
endpackage

// ===== hw/rtl/sll_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module sll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/sorted_linked_list_engine.sv =====
// Top level: sorted list engine over linked node memories.
`timescale 1ns / 1ps
// Sorted list engine. Holds up to CAPACITY signed values as a doubly linked
// list in three node RAMs (value, next link, prev link) plus a free chain.
// One item at a time: insert, remove at position, read at position, find.
// Each item walks the list one node at a time: S_RD issues the RAM read of
// the node and S_RW decides on the registered read data. Remove and read
// walk to the position, insert walks to its slot, find walks to the match.
// After reset a clearing pass builds the free chain in the link RAMs; no
// item is accepted during it (config writes are taken). Results sit in an
// output register, so the next item is taken while the last result waits;
// that item only holds in its final cycle until the waiting result has gone.
module sorted_linked_list_engine #(
  parameter int CAPACITY    = sll_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = sll_pkg::VALUE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sll_pkg::sll_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sll_pkg::sll_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import sll_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FREE  = 4'd2;  // read next of free head
  localparam logic [3:0] S_FREEW = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;  // issue read of node k
  localparam logic [3:0] S_RW    = 4'd5;  // read data valid, decide
  localparam logic [3:0] S_U1    = 4'd6;
  localparam logic [3:0] S_U2    = 4'd7;
  localparam logic [3:0] S_U3    = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]             state_r, state_nxt;
  logic                   order_r;
  sll_in_t                item_r;
  logic [VALUE_WIDTH-1:0] v_r;
  logic [LW-1:0]          head_r, head_nxt, free_r, free_nxt;
  logic [LW-1:0]          cnt_r, cnt_nxt;
  logic [LW-1:0]          k_r, k_nxt, bef_r, bef_nxt, n_r, n_nxt;
  logic [LW-1:0]          p_r, p_nxt, q_r, q_nxt;
  logic [LW-1:0]          pos_r, pos_nxt;
  logic [VALUE_WIDTH-1:0] res_r, res_nxt;
  logic [1:0]             stat_r, stat_nxt;
  logic [LW-1:0]          fpos_r, fpos_nxt;
  logic [AW-1:0]          clr_r;
  logic                   ov_r;
  sll_out_t               out_r, out_nxt;
  logic                   done_go;  // result moves into the output register

  // RAM ports
  logic                   v_we, n_we, p_we;
  logic [AW-1:0]          v_wa, n_wa, p_wa, rd_a;
  logic [VALUE_WIDTH-1:0] v_wd, v_rd;
  logic [LW-1:0]          n_wd, p_wd, n_rd, p_rd;

  sll_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val (
    .clk, .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(rd_a), .rdata(v_rd));
  sll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next (
    .clk, .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(rd_a), .rdata(n_rd));
  sll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(rd_a), .rdata(p_rd));

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_data  = out_r;
  assign done_go   = (state_r == S_DONE) && (!ov_r || out_ready);

  always_comb begin
    out_nxt                = '0;
    out_nxt.status         = stat_r;
    out_nxt.result_value   = 32'(res_r);
    out_nxt.found_position = 4'(fpos_r);
    out_nxt.entry_count    = 5'(cnt_r);
  end

  // insert ordering: new value goes before stored value
  logic goes_before;
  assign goes_before = order_r ? ($signed(v_r) >= $signed(v_rd))
                               : ($signed(v_r) <= $signed(v_rd));

  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r; free_nxt = free_r; cnt_nxt = cnt_r;
    k_nxt = k_r; bef_nxt = bef_r; n_nxt = n_r; p_nxt = p_r; q_nxt = q_r;
    pos_nxt = pos_r; res_nxt = res_r; stat_nxt = stat_r; fpos_nxt = fpos_r;
    v_we = 1'b0; n_we = 1'b0; p_we = 1'b0;
    v_wa = AW'(n_r); n_wa = clr_r; p_wa = clr_r;
    v_wd = v_r; n_wd = '0; p_wd = NIL;
    rd_a = AW'(k_r);
    unique case (state_r)
      S_CLEAR: begin
        n_we = 1'b1; p_we = 1'b1;
        n_wd = LW'(clr_r) + LW'(1);
        if (clr_r == AW'(CAPACITY - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          res_nxt = '0; stat_nxt = ST_OK; fpos_nxt = '0;
          k_nxt = head_r; bef_nxt = NIL; pos_nxt = '0;
          unique case (in_data.opcode)
            OP_INSERT: begin
              if (free_r == NIL) begin
                stat_nxt = ST_FULL; state_nxt = S_DONE;
              end else begin
                n_nxt = free_r; state_nxt = S_FREE;
              end
            end
            OP_REMOVE, OP_READ: begin
              if (LW'(in_data.position) >= cnt_r) begin
                stat_nxt = ST_BAD_POS; state_nxt = S_DONE;
              end else begin
                state_nxt = S_RD;
              end
            end
            default: state_nxt = S_RD;
          endcase
        end
      end
      S_FREE: begin
        rd_a = AW'(n_r);
        state_nxt = S_FREEW;
      end
      S_FREEW: begin
        free_nxt = n_rd;
        v_we = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        if (k_r == NIL) begin
          if (item_r.opcode == OP_FIND) begin
            stat_nxt = ST_NOTFOUND; state_nxt = S_DONE;
          end else begin
            state_nxt = S_U1;
          end
        end else begin
          state_nxt = S_RW;
        end
      end
      S_RW: begin
        state_nxt = S_RD;
        unique case (item_r.opcode)
          OP_INSERT: begin
            if (goes_before) begin
              state_nxt = S_U1;
            end else begin
              bef_nxt = k_r; k_nxt = n_rd;
            end
          end
          OP_FIND: begin
            if (v_rd == v_r) begin
              fpos_nxt = pos_r; state_nxt = S_DONE;
            end else begin
              k_nxt = n_rd; pos_nxt = pos_r + LW'(1);
            end
          end
          default: begin
            if (pos_r == LW'(item_r.position)) begin
              res_nxt = v_rd; p_nxt = p_rd; q_nxt = n_rd;
              state_nxt = (item_r.opcode == OP_REMOVE) ? S_U1 : S_DONE;
            end else begin
              k_nxt = n_rd; pos_nxt = pos_r + LW'(1);
            end
          end
        endcase
      end
      S_U1: begin
        if (item_r.opcode == OP_INSERT) begin
          n_we = 1'b1; n_wa = AW'(n_r); n_wd = k_r;
          p_we = 1'b1; p_wa = AW'(n_r); p_wd = bef_r;
        end else begin
          n_we = 1'b1; n_wa = AW'(k_r); n_wd = free_r;
          p_we = 1'b1; p_wa = AW'(k_r); p_wd = NIL;
        end
        state_nxt = S_U2;
      end
      S_U2: begin
        if (item_r.opcode == OP_INSERT) begin
          if (bef_r != NIL) begin
            n_we = 1'b1; n_wa = AW'(bef_r); n_wd = n_r;
          end else begin
            head_nxt = n_r;
          end
          if (k_r != NIL) begin
            p_we = 1'b1; p_wa = AW'(k_r); p_wd = n_r;
          end
          cnt_nxt = cnt_r + LW'(1);
          state_nxt = S_DONE;
        end else begin
          if (p_r != NIL) begin
            n_we = 1'b1; n_wa = AW'(p_r); n_wd = q_r;
          end else begin
            head_nxt = q_r;
          end
          if (q_r != NIL) begin
            p_we = 1'b1; p_wa = AW'(q_r); p_wd = p_r;
          end
          state_nxt = S_U3;
        end
      end
      S_U3: begin
        free_nxt = k_r;
        cnt_nxt = cnt_r - LW'(1);
        state_nxt = S_DONE;
      end
      // hold here while the previous result still waits
      S_DONE: begin
        if (done_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      order_r <= 1'b0;
      head_r  <= NIL;
      free_r  <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      free_r  <= free_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + AW'(1);
      if (cfg_valid && cfg_ready) order_r <= cfg_data;
      if (done_go) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
      v_r    <= VALUE_WIDTH'($signed(in_data.data_value));
    end
    if (done_go) out_r <= out_nxt;
    k_r <= k_nxt; bef_r <= bef_nxt; n_r <= n_nxt; p_r <= p_nxt; q_r <= q_nxt;
    pos_r <= pos_nxt; res_r <= res_nxt; stat_r <= stat_nxt; fpos_r <= fpos_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NIL) else $error("count above capacity");
  a_full_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && cnt_r == NIL) |-> free_r == NIL)
    else $error("full list with free node");
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && cnt_r == '0) |-> head_r == NIL)
    else $error("empty list with head");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("waiting result changed");
endmodule
